// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the receiver's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SBFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SBFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/sbfr_pkg.sv =====
package sbfr_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] MIN_LENGTH = 8'd2;

    localparam logic [1:0] CFG_OWN_ID = 2'd0;
    localparam logic [1:0] CFG_BCAST_ID = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

    localparam logic [7:0] RST_OWN_ID = 8'd1;
    localparam logic [7:0] RST_BCAST_ID = 8'd254;
    localparam logic [7:0] RST_MAX_LENGTH = 8'd16;

    localparam logic [1:0] STATUS_GOOD = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] frame_id;
        logic [7:0] instruction;
        logic [7:0] param_count;
        logic [7:0] first_param;
        logic [7:0] second_param;
        logic [1:0] status;
        logic       addressed;
        logic       is_broadcast;
    } t_result;

endpackage

// ===== rtl/sbfr_core.sv =====
module sbfr_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_own_id,
    input  logic [7:0]          i_bcast_id,
    input  logic [7:0]          i_max_length,
    output logic                o_emit,
    output sbfr_pkg::t_result   o_result
);
    import sbfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_INSTR,
        PH_PARAM,
        PH_CHECK
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_last_byte;
    logic [7:0] r_id, n_id;
    logic [7:0] r_length, n_length;
    logic [7:0] r_instr, n_instr;
    logic [7:0] r_param_a, n_param_a;
    logic [7:0] r_param_b, n_param_b;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_left, n_left;

    logic       bc;
    logic [7:0] body_len;
    logic [7:0] param_idx;

    assign bc = (r_id == i_bcast_id);
    assign body_len = r_length - MIN_LENGTH;
    assign param_idx = body_len - r_left;

    always_comb begin
        n_phase = r_phase;
        n_id = r_id;
        n_length = r_length;
        n_instr = r_instr;
        n_param_a = r_param_a;
        n_param_b = r_param_b;
        n_sum = r_sum;
        n_left = r_left;
        o_emit = 1'b0;
        o_result.frame_id = r_id;
        o_result.instruction = 8'd0;
        o_result.param_count = 8'd0;
        o_result.first_param = 8'd0;
        o_result.second_param = 8'd0;
        o_result.status = STATUS_LENGTH;
        o_result.addressed = (r_id == i_own_id) || bc;
        o_result.is_broadcast = bc;

        if (r_last_byte == HDR_BYTE && i_byte == HDR_BYTE) begin
            n_phase = PH_ID;
            n_id = 8'd0;
            n_length = 8'd0;
            n_instr = 8'd0;
            n_param_a = 8'd0;
            n_param_b = 8'd0;
            n_sum = 8'd0;
            n_left = 8'd0;
        end else begin
            case (r_phase)
                PH_ID: begin
                    n_id = i_byte;
                    n_sum = i_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_length = i_byte;
                    if (i_byte < MIN_LENGTH || i_byte > i_max_length) begin
                        o_emit = 1'b1;
                        n_phase = PH_HUNT;
                    end else begin
                        n_sum = r_sum + i_byte;
                        n_left = i_byte - MIN_LENGTH;
                        n_phase = PH_INSTR;
                    end
                end
                PH_INSTR: begin
                    n_instr = i_byte;
                    n_sum = r_sum + i_byte;
                    n_phase = (r_left != 8'd0) ? PH_PARAM : PH_CHECK;
                end
                PH_PARAM: begin
                    if (param_idx == 8'd0) begin
                        n_param_a = i_byte;
                    end else if (param_idx == 8'd1) begin
                        n_param_b = i_byte;
                    end
                    n_sum = r_sum + i_byte;
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_emit = 1'b1;
                    o_result.instruction = r_instr;
                    o_result.param_count = body_len;
                    o_result.first_param = r_param_a;
                    o_result.second_param = r_param_b;
                    o_result.status = (~r_sum == i_byte) ? STATUS_GOOD : STATUS_CHECKSUM;
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_last_byte <= 8'd0;
            r_id <= 8'd0;
            r_length <= 8'd0;
            r_instr <= 8'd0;
            r_param_a <= 8'd0;
            r_param_b <= 8'd0;
            r_sum <= 8'd0;
            r_left <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_last_byte <= i_byte;
            r_id <= n_id;
            r_length <= n_length;
            r_instr <= n_instr;
            r_param_a <= n_param_a;
            r_param_b <= n_param_b;
            r_sum <= n_sum;
            r_left <= n_left;
        end
    end

endmodule

// ===== rtl/servo_bus_frame_receiver_unit.sv =====
// Servo bus frame receiver. Received bus bytes enter one item at a time on
// the i_valid / o_ready channel. The block finds the two-byte 0xFF 0xFF
// header, collects id, length, instruction, parameters and checksum, and
// emits one result item per finished frame, or one at once for a length out
// of range, on the o_valid / i_ready channel. Bytes that end no frame give no
// result item.
// A byte is registered in the input register and processed by the frame logic
// once the output register is free or being read; any result is then written
// into the output register, which drives o_valid. One byte is taken in every
// cycle while the output does not stall; the frame state is updated once per byte.
// The own id, broadcast id and maximum length registers are written over the
// i_cfg_valid / o_cfg_ready channel (index 0, 1, 2; other indexes are
// ignored) and should only be written while the block is idle.
// Reset clears the frame state, the pipeline and the registers to their
// defaults. When the receiver stalls, the result stays in the output register
// and one more byte may wait in the input register; o_ready then drops.
`include "assert_macros.svh"

module servo_bus_frame_receiver_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_frame_id,
    output logic [7:0] o_instruction,
    output logic [7:0] o_param_count,
    output logic [7:0] o_first_param,
    output logic [7:0] o_second_param,
    output logic [1:0] o_status,
    output logic       o_addressed,
    output logic       o_is_broadcast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import sbfr_pkg::*;

    logic [7:0] r_own_id;
    logic [7:0] r_bcast_id;
    logic [7:0] r_max_length;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       emit;
    t_result    result;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    sbfr_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_byte         (r_in_byte),
        .i_own_id       (r_own_id),
        .i_bcast_id     (r_bcast_id),
        .i_max_length   (r_max_length),
        .o_emit         (emit),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= RST_OWN_ID;
            r_bcast_id <= RST_BCAST_ID;
            r_max_length <= RST_MAX_LENGTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OWN_ID:       r_own_id <= i_cfg_data;
                CFG_BCAST_ID:     r_bcast_id <= i_cfg_data;
                CFG_MAX_LENGTH:   r_max_length <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_frame_id = r_out.frame_id;
    assign o_instruction = r_out.instruction;
    assign o_param_count = r_out.param_count;
    assign o_first_param = r_out.first_param;
    assign o_second_param = r_out.second_param;
    assign o_status = r_out.status;
    assign o_addressed = r_out.addressed;
    assign o_is_broadcast = r_out.is_broadcast;

    `SBFR_ASSERT(a_len_err_empty,
        (o_valid && o_status == STATUS_LENGTH) |->
        (o_instruction == 8'd0 && o_param_count == 8'd0 && o_first_param == 8'd0),
        "length error item carries frame data")
    `SBFR_ASSERT(a_bc_addressed, o_valid && o_is_broadcast |-> o_addressed,
        "broadcast item not marked addressed")
    `SBFR_ASSERT(a_status_code, o_valid |-> (o_status <= STATUS_LENGTH), "undefined status code")
    `SBFR_ASSERT(a_full_stall, (r_in_valid && r_out_valid && !i_ready) |-> !o_ready,
        "input taken while both stages are blocked")
    `SBFR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result item present after reset")

endmodule

// ===== test/tb_servo_bus_frame_receiver_unit.sv =====
`timescale 1ns / 100ps

module tb_servo_bus_frame_receiver_unit;
    import sbfr_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [2:0] {
        SEEK_HEADER,
        TAKE_ID,
        TAKE_LENGTH,
        TAKE_INSTR,
        TAKE_PARAMS,
        TAKE_CHECKSUM
    } t_rx_phase;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    want;
    } t_stim_row;

    localparam t_result NO_FRAME = '0;
    localparam t_result PING_OK =
        '{8'h01, 8'h01, 8'h00, 8'h00, 8'h00, STATUS_GOOD, 1'b1, 1'b0};
    localparam t_result LEN_OVER =
        '{8'h05, 8'h00, 8'h00, 8'h00, 8'h00, STATUS_LENGTH, 1'b0, 1'b0};
    localparam t_result LEN_ZERO =
        '{8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, STATUS_LENGTH, 1'b1, 1'b1};

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_frame_id;
    logic [7:0] o_instruction;
    logic [7:0] o_param_count;
    logic [7:0] o_first_param;
    logic [7:0] o_second_param;
    logic [1:0] o_status;
    logic       o_addressed;
    logic       o_is_broadcast;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = 2'd0;
    logic [7:0] i_cfg_data = 8'h00;

    logic [7:0] own_id_q = RST_OWN_ID;
    logic [7:0] bcast_id_q = RST_BCAST_ID;
    logic [7:0] max_len_q = RST_MAX_LENGTH;

    logic [7:0] rx_last = 8'h00;
    t_rx_phase  rx_phase = SEEK_HEADER;
    logic [7:0] frm_id = 8'h00;
    logic [7:0] frm_len = 8'h00;
    logic [7:0] frm_instr = 8'h00;
    logic [7:0] frm_p0 = 8'h00;
    logic [7:0] frm_p1 = 8'h00;
    logic [7:0] frm_sum = 8'h00;
    logic [7:0] frm_left = 8'h00;

    t_result pending_frames[$];
    int      mismatches = 0;
    int      bytes_sent = 0;
    int      frames_checked = 0;
    int      status_seen[3] = '{0, 0, 0};
    int      settings_used = 1;
    int      quiet_cycles = 0;
    bit      steady = 1'b0;

    t_stim_row directed_rows[32] = '{
        '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'h01, 1'b0, NO_FRAME}, '{8'h02, 1'b0, NO_FRAME},
        '{8'h01, 1'b0, NO_FRAME}, '{8'hFB, 1'b1, PING_OK},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'h05, 1'b0, NO_FRAME}, '{8'h11, 1'b1, LEN_OVER},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'hFE, 1'b0, NO_FRAME}, '{8'h00, 1'b1, LEN_ZERO},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'h02, 1'b0, NO_FRAME}, '{8'h04, 1'b0, NO_FRAME},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'h03, 1'b0, NO_FRAME},
        '{8'h02, 1'b0, NO_FRAME}, '{8'h07, 1'b0, NO_FRAME},
        '{8'hF3, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
        '{8'h03, 1'b0, NO_FRAME}, '{8'h80, 1'b0, NO_FRAME},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'h7E, 1'b0, NO_FRAME}
    };

    servo_bus_frame_receiver_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_id     (o_frame_id),
        .o_instruction  (o_instruction),
        .o_param_count  (o_param_count),
        .o_first_param  (o_first_param),
        .o_second_param (o_second_param),
        .o_status       (o_status),
        .o_addressed    (o_addressed),
        .o_is_broadcast (o_is_broadcast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result frame_result(input logic [7:0] instr, input logic [7:0] count,
                                             input logic [7:0] p0, input logic [7:0] p1,
                                             input logic [1:0] st);
        t_result r;
        r.frame_id = frm_id;
        r.instruction = instr;
        r.param_count = count;
        r.first_param = p0;
        r.second_param = p1;
        r.status = st;
        r.is_broadcast = (frm_id == bcast_id_q);
        r.addressed = (frm_id == own_id_q) || r.is_broadcast;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, output logic made, output t_result r);
        logic [7:0] earlier;
        logic [7:0] slot;
        earlier = rx_last;
        rx_last = b;
        made = 1'b0;
        r = '0;
        if (earlier == HDR_BYTE && b == HDR_BYTE) begin
            frm_id = 8'h00;
            frm_len = 8'h00;
            frm_instr = 8'h00;
            frm_p0 = 8'h00;
            frm_p1 = 8'h00;
            frm_sum = 8'h00;
            frm_left = 8'h00;
            rx_phase = TAKE_ID;
            return;
        end
        case (rx_phase)
            TAKE_ID: begin
                frm_id = b;
                frm_sum = b;
                rx_phase = TAKE_LENGTH;
            end
            TAKE_LENGTH: begin
                frm_len = b;
                if (b < MIN_LENGTH || b > max_len_q) begin
                    r = frame_result(8'h00, 8'h00, 8'h00, 8'h00, STATUS_LENGTH);
                    made = 1'b1;
                    rx_phase = SEEK_HEADER;
                end else begin
                    frm_sum = frm_sum + b;
                    frm_left = b - MIN_LENGTH;
                    rx_phase = TAKE_INSTR;
                end
            end
            TAKE_INSTR: begin
                frm_instr = b;
                frm_sum = frm_sum + b;
                rx_phase = (frm_left != 8'h00) ? TAKE_PARAMS : TAKE_CHECKSUM;
            end
            TAKE_PARAMS: begin
                slot = frm_len - MIN_LENGTH - frm_left;
                if (slot == 8'd0) begin
                    frm_p0 = b;
                end else if (slot == 8'd1) begin
                    frm_p1 = b;
                end
                frm_sum = frm_sum + b;
                frm_left = frm_left - 8'd1;
                if (frm_left == 8'h00) begin
                    rx_phase = TAKE_CHECKSUM;
                end
            end
            TAKE_CHECKSUM: begin
                r = frame_result(frm_instr, frm_len - MIN_LENGTH, frm_p0, frm_p1,
                                 (b == ~frm_sum) ? STATUS_GOOD : STATUS_CHECKSUM);
                made = 1'b1;
                rx_phase = SEEK_HEADER;
            end
            default: rx_phase = SEEK_HEADER;
        endcase
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed, input t_result given);
        logic    made;
        t_result r;
        while (!steady && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        parse_byte(b, made, r);
        if (typed) begin
            pending_frames.push_back(given);
        end else if (made) begin
            pending_frames.push_back(r);
        end
        bytes_sent++;
    endtask

    task automatic send_random_frame();
        logic [7:0]  frame_bytes[$];
        logic [7:0]  fid;
        logic [7:0]  flen;
        logic [7:0]  fsum;
        logic [7:0]  b;
        int unsigned pick;
        int unsigned keep;
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 6)) begin
                b = ($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom_range(255));
                send_byte(b, 1'b0, NO_FRAME);
            end
            return;
        end
        case ($urandom_range(2))
            0: fid = own_id_q;
            1: fid = bcast_id_q;
            default: fid = 8'($urandom_range(254));
        endcase
        pick = $urandom_range(99);
        if (max_len_q < MIN_LENGTH) begin
            flen = 8'($urandom_range(255));
        end else if (pick < 10) begin
            if (max_len_q == 8'hFF || pick < 4) begin
                flen = 8'($urandom_range(1));
            end else begin
                flen = 8'($urandom_range(255, max_len_q + 1));
            end
        end else if (pick < 18 && (max_len_q <= 8'd32 || pick < 11)) begin
            flen = max_len_q;
        end else begin
            flen = 8'($urandom_range(2, (max_len_q < 8'd7) ? max_len_q : 8'd7));
        end
        frame_bytes = '{HDR_BYTE, HDR_BYTE, fid, flen};
        if (flen >= MIN_LENGTH && flen <= max_len_q) begin
            fsum = fid + flen;
            for (int i = 0; i < flen - 1; i++) begin
                b = ($urandom_range(7) == 0) ? HDR_BYTE : 8'($urandom_range(255));
                fsum = fsum + b;
                frame_bytes.push_back(b);
            end
            fsum = ~fsum;
            if ($urandom_range(99) < 15) begin
                fsum = fsum ^ 8'($urandom_range(1, 255));
            end
            frame_bytes.push_back(fsum);
        end
        keep = frame_bytes.size();
        if ($urandom_range(99) < 8) begin
            keep = $urandom_range(1, keep - 1);
        end
        for (int i = 0; i < keep; i++) begin
            send_byte(frame_bytes[i], 1'b0, NO_FRAME);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_OWN_ID: own_id_q = val;
            CFG_BCAST_ID: bcast_id_q = val;
            CFG_MAX_LENGTH: max_len_q = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_frames.size() == 0) begin
                flag_mismatch($sformatf("result for id %0h with none expected", o_frame_id));
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                status_seen[want.status]++;
                check_field("frame_id", o_frame_id, want.frame_id);
                check_field("instruction", o_instruction, want.instruction);
                check_field("param_count", o_param_count, want.param_count);
                check_field("first_param", o_first_param, want.first_param);
                check_field("second_param", o_second_param, want.second_param);
                check_field("status", 8'(o_status), 8'(want.status));
                check_field("addressed", 8'(o_addressed), 8'(want.addressed));
                check_field("is_broadcast", 8'(o_is_broadcast), 8'(want.is_broadcast));
            end
        end
        i_ready <= steady || ($urandom_range(99) >= 21);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("No handshake for %0d cycles, %0d results outstanding.",
                     quiet_cycles, pending_frames.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] set_own;
        logic [7:0] set_bc;
        logic [7:0] set_max;
        int         budget;
        int         phase_start;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int ph = 0; ph < 7; ph++) begin
            budget = 120;
            case (ph)
                0: begin
                    set_own = 8'd0;
                    set_bc = 8'hFF;
                    set_max = 8'hFF;
                end
                1: begin
                    set_own = 8'd253;
                    set_bc = 8'd0;
                    set_max = MIN_LENGTH;
                    budget = 100;
                end
                4: begin
                    set_own = 8'($urandom_range(253));
                    set_bc = 8'($urandom_range(255));
                    set_max = 8'd1;
                    budget = 40;
                end
                5: begin
                    set_own = 8'($urandom_range(253));
                    set_bc = 8'($urandom_range(255));
                    set_max = 8'd0;
                    budget = 40;
                end
                6: begin
                    set_own = RST_OWN_ID;
                    set_bc = RST_BCAST_ID;
                    set_max = RST_MAX_LENGTH;
                    budget = 130;
                end
                default: begin
                    set_own = 8'($urandom_range(253));
                    set_bc = 8'($urandom_range(255));
                    set_max = 8'($urandom_range(2, 255));
                end
            endcase
            drain();
            write_reg(CFG_OWN_ID, set_own);
            write_reg(CFG_BCAST_ID, set_bc);
            write_reg(CFG_MAX_LENGTH, set_max);
            if (ph == 5) begin
                write_reg(CFG_UNUSED, 8'($urandom_range(255)));
            end
            i_cfg_valid <= 1'b0;
            settings_used++;
            steady = (ph == 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < budget) begin
                send_random_frame();
            end
            steady = 1'b0;
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d bus bytes under %0d register settings, checked %0d results.",
                 bytes_sent, settings_used, frames_checked);
        $display("Results by status: %0d good, %0d checksum errors, %0d length errors.",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
